// ----- hw/rtl/sorted_table_binary_insert_unit_defines.svh -----
// Assertion macros for the checker file.
`ifndef SORTED_TABLE_BINARY_INSERT_UNIT_DEFINES_SVH
`define SORTED_TABLE_BINARY_INSERT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define STBI_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("stbi assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define STBI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("stbi assertion failed");

`endif

// ----- hw/rtl/stbi_pkg.sv -----
package stbi_pkg;

  // Fixed field widths of the request and response
  localparam int unsigned ModeFieldW = 2;
  localparam int unsigned KeyFieldW  = 32;
  localparam int unsigned PosFieldW  = 9;

  // Operation codes; the remaining code is a no-op
  typedef enum logic [ModeFieldW-1:0] {
    MODE_INSERT = 2'd0,
    MODE_FIND   = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_e;

  typedef struct packed {
    logic [ModeFieldW-1:0] mode;
    logic [KeyFieldW-1:0]  key;
  } req_t;

  typedef struct packed {
    logic                 found;
    logic                 inserted;
    logic [PosFieldW-1:0] location;
    logic                 table_full;
    logic [PosFieldW-1:0] entry_count;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMPARE,
    ST_DECIDE,
    ST_SHIFT_PRIME,
    ST_SHIFT,
    ST_WRITE_KEY,
    ST_FINISH
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;         // capture request, open the search range
    logic probe;        // read the middle entry
    logic compare;      // narrow the range on the read entry
    logic miss;         // search ended without a match
    logic set_full;     // insert refused, table full
    logic shift_prime;  // read the top valid entry
    logic shift_step;   // move one entry up, read the next lower one
    logic write_key;    // store the key at the search position
    logic finish;       // load the response register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic range_open;
    logic key_eq;
    logic is_insert;
    logic refuse_dup;
    logic tbl_full;
    logic pos_at_end;
    logic shift_more;
  } status_t;

endpackage

// ----- hw/rtl/stbi_datapath.sv -----
module stbi_datapath #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned KEY_BITS    = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  stbi_pkg::req_t    in_req_i,
  input  stbi_pkg::cmd_t    cmd_i,
  output stbi_pkg::status_t status_o,
  output stbi_pkg::rsp_t    rsp_o
);
  import stbi_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic [KEY_BITS-1:0] mem [TABLE_DEPTH];

  logic                keep_q;
  logic [CW-1:0]       count_q, count_d;
  logic [KEY_BITS-1:0] key_q;
  logic [ModeFieldW-1:0] mode_q;
  logic [CW-1:0]       lo_q, hix_q, pos_q;
  logic [AW-1:0]       mid_q, r_q;
  logic                hit_q, ins_q, full_q;
  logic [KEY_BITS-1:0] rd_data_q;
  rsp_t                rsp_q;

  logic [CW:0]         sum_w;
  logic [AW-1:0]       mid_w;
  logic                rd_en, wr_en;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic [KEY_BITS-1:0] wr_data;

  // Probe index: middle of [lo, hix-1], rounded down
  assign sum_w = {1'b0, lo_q} + {1'b0, hix_q} - (CW + 1)'(1);
  assign mid_w = AW'(sum_w >> 1);

  // Status toward the controller
  assign status_o.range_open = lo_q < hix_q;
  assign status_o.key_eq     = rd_data_q == key_q;
  assign status_o.is_insert  = mode_q == MODE_INSERT;
  assign status_o.refuse_dup = hit_q & ~keep_q;
  assign status_o.tbl_full   = count_q == CW'(TABLE_DEPTH);
  assign status_o.pos_at_end = pos_q == count_q;
  assign status_o.shift_more = CW'(r_q) > pos_q;

  // Memory port selection
  assign rd_en   = cmd_i.probe | cmd_i.shift_prime | (cmd_i.shift_step & status_o.shift_more);
  assign rd_addr = cmd_i.probe       ? mid_w :
                   cmd_i.shift_prime ? AW'(count_q - CW'(1)) :
                                       r_q - AW'(1);
  assign wr_en   = cmd_i.shift_step | cmd_i.write_key;
  assign wr_addr = cmd_i.write_key ? AW'(pos_q) : r_q + AW'(1);
  assign wr_data = cmd_i.write_key ? key_q : rd_data_q;

  // Key memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Entry count
  always_comb begin
    count_d = count_q;
    if (cmd_i.load && in_req_i.mode == MODE_CLEAR) begin
      count_d = '0;
    end else if (cmd_i.write_key) begin
      count_d = count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      keep_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cfg_we_i) begin
        keep_q <= cfg_wdata_i;
      end
    end
  end

  // Search and shift registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q  <= KEY_BITS'(in_req_i.key);
      mode_q <= in_req_i.mode;
      lo_q   <= '0;
      hix_q  <= count_q;
      pos_q  <= '0;
      hit_q  <= 1'b0;
      ins_q  <= 1'b0;
      full_q <= 1'b0;
    end
    if (cmd_i.probe) begin
      mid_q <= mid_w;
    end
    if (cmd_i.compare) begin
      if (rd_data_q < key_q) begin
        lo_q <= CW'(mid_q) + CW'(1);
      end else if (rd_data_q > key_q) begin
        hix_q <= CW'(mid_q);
      end else begin
        pos_q <= CW'(mid_q);
        hit_q <= 1'b1;
      end
    end
    if (cmd_i.miss) begin
      pos_q <= lo_q;
    end
    if (cmd_i.set_full) begin
      full_q <= 1'b1;
    end
    if (cmd_i.shift_prime) begin
      r_q <= AW'(count_q - CW'(1));
    end else if (cmd_i.shift_step && status_o.shift_more) begin
      r_q <= r_q - AW'(1);
    end
    if (cmd_i.write_key) begin
      ins_q <= 1'b1;
    end
  end

  // Response register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      rsp_q.found       <= hit_q;
      rsp_q.inserted    <= ins_q;
      rsp_q.location    <= PosFieldW'(pos_q);
      rsp_q.table_full  <= full_q;
      rsp_q.entry_count <= PosFieldW'(count_q);
    end
  end

  assign rsp_o = rsp_q;

endmodule

// ----- hw/rtl/stbi_ctrl.sv -----
module stbi_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic [stbi_pkg::ModeFieldW-1:0] in_mode_i,
  input  logic                            out_stall_i,
  input  stbi_pkg::status_t               status_i,
  output stbi_pkg::cmd_t                  cmd_o,
  output logic                            in_stall_o,
  output logic                            out_valid_o
);
  import stbi_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept, slot_free;

  assign in_stall_o  = state_q != ST_IDLE;
  assign accept      = in_valid_i && state_q == ST_IDLE;
  assign slot_free   = ~out_valid_q | ~out_stall_i;
  assign out_valid_o = out_valid_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_mode_i == MODE_INSERT || in_mode_i == MODE_FIND) begin
            state_d = ST_SEARCH;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_SEARCH: begin
        state_d = status_i.range_open ? ST_COMPARE : ST_DECIDE;
      end
      ST_COMPARE: begin
        state_d = status_i.key_eq ? ST_DECIDE : ST_SEARCH;
      end
      ST_DECIDE: begin
        if (!status_i.is_insert || status_i.refuse_dup || status_i.tbl_full) begin
          state_d = ST_FINISH;
        end else if (status_i.pos_at_end) begin
          state_d = ST_WRITE_KEY;
        end else begin
          state_d = ST_SHIFT_PRIME;
        end
      end
      ST_SHIFT_PRIME: begin
        state_d = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (!status_i.shift_more) begin
          state_d = ST_WRITE_KEY;
        end
      end
      ST_WRITE_KEY: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load = accept;
      end
      ST_SEARCH: begin
        cmd_o.probe = status_i.range_open;
        cmd_o.miss  = ~status_i.range_open;
      end
      ST_COMPARE: begin
        cmd_o.compare = 1'b1;
      end
      ST_DECIDE: begin
        cmd_o.set_full = status_i.is_insert & ~status_i.refuse_dup & status_i.tbl_full;
      end
      ST_SHIFT_PRIME: begin
        cmd_o.shift_prime = 1'b1;
      end
      ST_SHIFT: begin
        cmd_o.shift_step = 1'b1;
      end
      ST_WRITE_KEY: begin
        cmd_o.write_key = 1'b1;
      end
      ST_FINISH: begin
        cmd_o.finish = slot_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // Response valid: set on finish, cleared when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- hw/rtl/sorted_table_binary_insert_unit.sv -----
// Channel   Direction  Handshake             Payload
// request   in         in_valid_i/in_stall_o   in_req_i   (mode, key)
// response  out        out_valid_o/out_stall_i out_rsp_o  (found .. entry_count)
// config    in         cfg_we_i                cfg_wdata_i (dup_keep)
//
// One request at a time. Each binary-search probe reads the middle entry from the
// key memory in the search state, then compares it in the compare state.
// An insert moves each entry above the search position up one place through
// the one-read, one-write key memory, then writes the key at that position.
// Reset clears the entry count and dup_keep; no memory clearing pass.
// A request may be taken while a response waits; the next one waits at finish.
module sorted_table_binary_insert_unit #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned KEY_BITS    = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  stbi_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output stbi_pkg::rsp_t out_rsp_o
);
  import stbi_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer
  stbi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_mode_i   (in_req_i.mode),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  // Key memory, search registers and response register
  stbi_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .rsp_o       (out_rsp_o)
  );

endmodule

// ----- hw/rtl/stbi_checker.sv -----
`include "sorted_table_binary_insert_unit_defines.svh"

module stbi_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input stbi_pkg::rsp_t out_rsp_o
);
  import stbi_pkg::*;

  // A stalled response holds
  `STBI_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_rsp_o))

  // One request in flight: a taken request closes the input
  `STBI_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // A stored key is never also reported as refused for space
  `STBI_ASSERT_NOW(a_ins_not_full, clk_i, rst_ni, out_valid_o, !(out_rsp_o.inserted && out_rsp_o.table_full))

  // Nothing is reported before a request has been taken
  `STBI_ASSERT_NEXT(a_no_spurious, clk_i, rst_ni, !out_valid_o && !in_stall_o && !in_valid_i, !out_valid_o)

endmodule

bind sorted_table_binary_insert_unit stbi_checker u_stbi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);
